// ===== hw/rtl/gha_pkg.sv =====
// Package for the generational handle allocator.
// Holds the handle layout, request mode codes and result status codes.
// No dependencies.
package gha_pkg;

  localparam int HANDLE_W    = 64;
  localparam int IDX_FIELD_W = 32;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

endpackage

// ===== hw/rtl/gha_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/generational_handle_allocator.sv =====
// Generational handle allocator. Release, query and the unused mode pass from the
// input transfer through S_REL, S_QCHK or S_NOP and then S_FIN to the output register.
// Allocate goes to S_GROW when the hint sits at the high-water mark, else to the
// free-slot scan, which reads one slot entry per cycle from the RAM and falls back
// to S_GROW if no slot is free. One request is in flight at a time; a stalled result
// holds off the next input. Reset (synchronous, active low) clears control state
// only; the slot RAM needs no clearing, since every entry used is written first.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [HANDLE_W-1:0] in_handle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HANDLE_W-1:0] out_new_handle,
  output logic                out_exists,
  output logic [1:0]          out_status
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int ENTRY_W = GEN_BITS + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_GROW = 3'd2;
  localparam logic [2:0] S_REL  = 3'd3;
  localparam logic [2:0] S_QCHK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_NOP  = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       hw_r, hw_nxt;
  logic [CNT_W-1:0]       hint_r, hint_nxt;
  logic [IDX_FIELD_W-1:0] req_idx_r;
  logic [GEN_BITS-1:0]    req_gen_r;
  logic [CNT_W-1:0]       scan_addr_r, scan_addr_nxt;
  logic [IDX_W-1:0]       chk_addr_r;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [HANDLE_W-1:0]    res_handle_r, res_handle_nxt;
  logic                   res_exists_r, res_exists_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic                   out_valid_r;
  logic [HANDLE_W-1:0]    out_handle_r;
  logic                   out_exists_r;
  logic [1:0]             out_status_r;

  // Slot RAM: each entry packs the in-use flag above the stored generation.
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic                   rd_in_use;
  logic [GEN_BITS-1:0]    rd_gen;
  logic [GEN_BITS-1:0]    reuse_gen;
  logic                   in_xfer;
  logic                   out_free;
  logic                   scan_issue;
  logic [IDX_FIELD_W-1:0] hw_wide;
  logic [IDX_FIELD_W-1:0] hint_wide;
  logic                   req_out_of_range;

  gha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_in_use = ram_rdata[ENTRY_W-1];
  assign rd_gen    = ram_rdata[GEN_BITS-1:0];
  // The generation wraps naturally at GEN_BITS bits.
  assign reuse_gen = rd_gen + GEN_BITS'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  // The output register can take a new result when it is empty or being drained.
  assign out_free  = !out_valid_r || out_ready;

  assign hw_wide          = IDX_FIELD_W'(hw_r);
  assign hint_wide        = IDX_FIELD_W'(hint_r);
  assign req_out_of_range = (req_idx_r >= hw_wide);
  // The scan keeps issuing reads until its address reaches the high-water mark.
  assign scan_issue       = (state_r == S_SCAN) && (scan_addr_r < hw_r);

  // A query issues its RAM read in the cycle of the input transfer; the scan
  // issues one read per cycle from its own address counter.
  assign ram_raddr = (state_r == S_IDLE) ? in_handle[IDX_W-1:0] : scan_addr_r[IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    hw_nxt         = hw_r;
    hint_nxt       = hint_r;
    scan_addr_nxt  = scan_addr_r;
    chk_vld_nxt    = 1'b0;
    res_handle_nxt = res_handle_r;
    res_exists_nxt = res_exists_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_addr_r;
    ram_wdata      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_handle_nxt = '0;
          res_exists_nxt = 1'b0;
          res_status_nxt = STATUS_DONE;
          scan_addr_nxt  = hint_r;
          case (in_mode)
            MODE_ALLOC: begin
              // With no slot between the hint and the mark, go straight to growth.
              state_nxt = (hint_r < hw_r) ? S_SCAN : S_GROW;
            end
            MODE_RELEASE: state_nxt = S_REL;
            MODE_QUERY:   state_nxt = S_QCHK;
            default:      state_nxt = S_NOP;
          endcase
        end
      end

      S_SCAN: begin
        // Reads are pipelined: the entry checked now was addressed last cycle.
        if (scan_issue) begin
          scan_addr_nxt = scan_addr_r + CNT_W'(1);
        end
        chk_vld_nxt = scan_issue;
        if (chk_vld_r && !rd_in_use) begin
          ram_we         = 1'b1;
          ram_waddr      = chk_addr_r;
          ram_wdata      = {1'b1, reuse_gen};
          hint_nxt       = CNT_W'(chk_addr_r) + CNT_W'(1);
          res_handle_nxt = {IDX_FIELD_W'(reuse_gen), IDX_FIELD_W'(chk_addr_r)};
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_FIN;
        end else if (!scan_issue) begin
          // Every slot up to the mark is taken.
          chk_vld_nxt = 1'b0;
          state_nxt   = S_GROW;
        end
      end

      S_GROW: begin
        if (hw_r < CNT_W'(SLOTS)) begin
          ram_we         = 1'b1;
          ram_waddr      = hw_r[IDX_W-1:0];
          ram_wdata      = {1'b1, {GEN_BITS{1'b0}}};
          hw_nxt         = hw_r + CNT_W'(1);
          hint_nxt       = hw_r + CNT_W'(1);
          res_handle_nxt = HANDLE_W'(hw_r);
        end else begin
          hint_nxt       = hw_r;
          res_status_nxt = STATUS_FULL;
        end
        state_nxt = S_FIN;
      end

      S_REL: begin
        if (req_idx_r == '0 || req_out_of_range) begin
          res_status_nxt = STATUS_RANGE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = req_idx_r[IDX_W-1:0];
          ram_wdata = {1'b0, req_gen_r};
          if (req_idx_r < hint_wide) begin
            hint_nxt = req_idx_r[CNT_W-1:0];
          end
        end
        state_nxt = S_FIN;
      end

      S_QCHK: begin
        // The generation is not compared; only the in-use flag matters.
        if (req_out_of_range) begin
          res_status_nxt = STATUS_RANGE;
        end else begin
          res_exists_nxt = (req_idx_r != '0) && rd_in_use;
        end
        state_nxt = S_FIN;
      end

      S_NOP: state_nxt = S_FIN;

      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= CNT_W'(1);
      hint_r      <= CNT_W'(1);
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hw_r      <= hw_nxt;
      hint_r    <= hint_nxt;
      chk_vld_r <= chk_vld_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    scan_addr_r  <= scan_addr_nxt;
    chk_addr_r   <= scan_addr_r[IDX_W-1:0];
    res_handle_r <= res_handle_nxt;
    res_exists_r <= res_exists_nxt;
    res_status_r <= res_status_nxt;
    if (in_xfer) begin
      req_idx_r <= in_handle[IDX_FIELD_W-1:0];
      req_gen_r <= in_handle[IDX_FIELD_W +: GEN_BITS];
    end
    if (state_r == S_FIN && out_free) begin
      out_handle_r <= res_handle_r;
      out_exists_r <= res_exists_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_handle = out_handle_r;
  assign out_exists     = out_exists_r;
  assign out_status     = out_status_r;

endmodule

// ===== hw/rtl/gha_checker.sv =====
// Port-level checker for the generational handle allocator, bound to the top.
// Depends on gha_pkg for handle layout and status codes.
module gha_port_checker
  import gha_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_mode,
  input logic [HANDLE_W-1:0] in_handle,
  input logic                out_valid,
  input logic                out_ready,
  input logic [HANDLE_W-1:0] out_new_handle,
  input logic                out_exists,
  input logic [1:0]          out_status
);

  // A result that is not taken holds steady.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_handle)
      && $stable(out_exists) && $stable(out_status))
    else $error("stalled result changed");

  // One request at a time: no transfer directly after a transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in flight");

  // A full pool never hands out a handle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_new_handle == '0 && !out_exists)
    else $error("handle returned with pool-full status");

  // An allocated handle never names the reserved slot and carries no query bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_handle != '0 |->
      out_new_handle[IDX_FIELD_W-1:0] != '0 && out_status == STATUS_DONE && !out_exists)
    else $error("bad allocated handle");

  // Only a defined status code is reported.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STATUS_DONE || out_status == STATUS_FULL
      || out_status == STATUS_RANGE)
    else $error("undefined status code");

endmodule

bind generational_handle_allocator gha_port_checker u_gha_checker (.*);

// ===== dv/gha_checker.sv =====
// Scoreboard for the generational handle allocator: watches both channels, keeps
// its own copy of the slot table and compares every result transfer in order.
// Depends on gha_pkg for the handle width and the mode and status codes.
module gha_checker
  import gha_pkg::*;
#(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [HANDLE_W-1:0] out_new_handle,
  input  logic                out_exists,
  input  logic [1:0]          out_status,
  output int                  error_count,
  output int                  pending_count
);

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic                exists;
    logic [1:0]          status;
  } response_t;

  localparam logic [31:0] GEN_MASK = 32'((64'd1 << GEN_BITS) - 64'd1);

  logic        slot_busy [SLOTS];
  logic [31:0] slot_gen  [SLOTS];
  int          hint;
  int          high_water;
  response_t   expected_q [$];

  // Applies one request to the slot table and returns the answer it should get.
  function automatic response_t next_response(logic [1:0] mode, logic [HANDLE_W-1:0] handle);
    response_t   rsp;
    logic [31:0] idx;
    logic [31:0] hgen;
    logic [31:0] g;
    int          slot;
    bit          found;
    rsp   = '0;
    idx   = handle[31:0];
    hgen  = handle[63:32] & GEN_MASK;
    g     = '0;
    slot  = 0;
    found = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        for (int i = hint; i < high_water && i < SLOTS; i++) begin
          if (!slot_busy[i]) begin
            slot  = i;
            g     = (slot_gen[i] + 32'd1) & GEN_MASK;
            found = 1'b1;
            break;
          end
        end
        if (!found && high_water < SLOTS) begin
          slot       = high_water;
          high_water = high_water + 1;
          g          = '0;
          found      = 1'b1;
        end
        if (found) begin
          slot_busy[slot] = 1'b1;
          slot_gen[slot]  = g;
          hint            = slot + 1;
          rsp.new_handle  = {g, 32'(slot)};
        end else begin
          hint       = high_water;
          rsp.status = STATUS_FULL;
        end
      end
      MODE_RELEASE: begin
        if (idx == 32'd0 || idx >= 32'(high_water)) begin
          rsp.status = STATUS_RANGE;
        end else begin
          slot_busy[int'(idx)] = 1'b0;
          slot_gen[int'(idx)]  = hgen;
          if (int'(idx) < hint) hint = int'(idx);
        end
      end
      MODE_QUERY: begin
        if (idx >= 32'(high_water)) begin
          rsp.status = STATUS_RANGE;
        end else if (idx != 32'd0 && slot_busy[int'(idx)]) begin
          rsp.exists = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic log_mismatch(string what, response_t want, response_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] mismatch (%s): expected handle %h exists %0b status %0d, got handle %h exists %0b status %0d",
               $realtime, what, want.new_handle, want.exists, want.status,
               got.new_handle, got.exists, got.status);
    end
  endtask

  always @(posedge clk) begin
    response_t want;
    response_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i] = 1'b0;
        slot_gen[i]  = '0;
      end
      hint        = 1;
      high_water  = 1;
      error_count = 0;
      expected_q.delete();
    end else begin
      // Results are matched before new requests are queued, so a stray result
      // cannot pair up with a request that arrives on the same edge.
      if (out_valid && out_ready) begin
        got = '{new_handle: out_new_handle, exists: out_exists, status: out_status};
        if (expected_q.size() == 0) begin
          log_mismatch("no request waiting", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) log_mismatch("field", want, got);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(next_response(in_mode, in_handle));
    end
    pending_count = expected_q.size();
  end

endmodule

// ===== dv/tb_generational_handle_allocator.sv =====
// Testbench top for the generational handle allocator: clock, reset, request
// stimulus and result back-pressure, with gha_checker doing all comparisons.
// Depends on gha_pkg, gha_checker and the allocator RTL.
module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int SLOTS    = 256;
  localparam int GEN_BITS = 32;

  // Mode 3 has no meaning in the block; it must be answered with all zeros.
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // The random part runs in segments, each leaning toward one kind of traffic.
  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_e;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_mode;
  logic [HANDLE_W-1:0] in_handle;
  logic                out_valid;
  logic                out_ready;
  logic [HANDLE_W-1:0] out_new_handle;
  logic                out_exists;
  logic [1:0]          out_status;
  int                  error_count;
  int                  pending_count;

  int                  burst_left;
  int                  random_items;
  int                  seg_len;
  bit                  first_seg;
  segment_e            seg_kind;
  logic [1:0]          mode;

  generational_handle_allocator #(
    .SLOTS   (SLOTS),
    .GEN_BITS(GEN_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_handle     (in_handle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_new_handle(out_new_handle),
    .out_exists    (out_exists),
    .out_status    (out_status)
  );

  gha_checker #(
    .SLOTS   (SLOTS),
    .GEN_BITS(GEN_BITS)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_handle     (in_handle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_new_handle(out_new_handle),
    .out_exists    (out_exists),
    .out_status    (out_status),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung handshake ends the run here. The allowance covers every request
  // doing a full-pool scan while the receiver stalls heavily, several times over.
  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  // Offers one request and returns at the falling edge after its transfer.
  // The sender works in bursts; between bursts valid drops for a random gap.
  // A burst that follows directly keeps valid high, so it is never lowered
  // and raised in the same step.
  task automatic issue(input logic [1:0] req_mode, input logic [HANDLE_W-1:0] req_handle);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_mode   <= req_mode;
    in_handle <= req_handle;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Indexes mostly land inside the pool, with some on the reserved slot, some
  // just past the pool and some anywhere in 32 bits. Generations favor the all-ones
  // value, so the wrap to zero on the next reuse comes up often.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    logic [31:0] idx;
    logic [31:0] gen;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 75)      idx = $urandom_range(1, SLOTS - 1);
    else if (r < 85) idx = '0;
    else if (r < 95) idx = $urandom_range(SLOTS, SLOTS + 40);
    else             idx = $urandom;
    r = $urandom_range(0, 99);
    if (r < 50)      gen = $urandom;
    else if (r < 70) gen = '1;
    else             gen = $urandom_range(0, 3);
    return {gen, idx};
  endfunction

  function automatic logic [1:0] pick_mode(segment_e kind);
    int r;
    int alloc_pct;
    int release_pct;
    r = $urandom_range(0, 99);
    case (kind)
      SEG_FILL: begin
        alloc_pct   = 88;
        release_pct = 5;
      end
      SEG_DRAIN: begin
        alloc_pct   = 25;
        release_pct = 55;
      end
      default: begin
        alloc_pct   = 45;
        release_pct = 30;
      end
    endcase
    if (r < 2)                            return MODE_RESERVED;
    if (r < 2 + alloc_pct)                return MODE_ALLOC;
    if (r < 2 + alloc_pct + release_pct)  return MODE_RELEASE;
    return MODE_QUERY;
  endfunction

  // Receiver: segments of random length with no, light or heavy stalling. The
  // fourth segment is a long hold-off while the sender keeps offering, so the
  // block fills up and stalls its input.
  initial begin
    int seg;
    int stall_pct;
    int seg_cycles;
    out_ready = 1'b0;
    seg = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (seg == 3) begin
        stall_pct  = 100;
        seg_cycles = 800;
      end else begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          default: stall_pct = 70;
        endcase
        seg_cycles = $urandom_range(10, 200);
      end
      repeat (seg_cycles) begin
        @(negedge clk);
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      seg++;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = MODE_ALLOC;
    in_handle  = '0;
    burst_left = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The pool starts with only the reserved slot, so a query of
    // index 1 and a release of index 0 are both out of range.
    issue(MODE_QUERY,    {32'd0, 32'd1});
    issue(MODE_RELEASE,  {32'd0, 32'd0});
    issue(MODE_ALLOC,    '0);
    issue(MODE_ALLOC,    '0);
    issue(MODE_ALLOC,    '0);
    issue(MODE_QUERY,    {32'h5a5a_a5a5, 32'd1});
    // Index zero is in range but never in use.
    issue(MODE_QUERY,    {32'd0, 32'd0});
    issue(MODE_QUERY,    {32'd0, 32'd200});
    issue(MODE_RELEASE,  {32'd0, 32'd5});
    // The stored all-ones generation wraps to zero when slot 2 is reused.
    issue(MODE_RELEASE,  {32'hffff_ffff, 32'd2});
    issue(MODE_QUERY,    {32'd0, 32'd2});
    issue(MODE_ALLOC,    '0);
    // A second release of a free slot still stores its generation.
    issue(MODE_RELEASE,  {32'h1234_5678, 32'd3});
    issue(MODE_RELEASE,  {32'h0000_abcd, 32'd3});
    issue(MODE_ALLOC,    '0);
    issue(MODE_RESERVED, '1);
    issue(MODE_QUERY,    '1);
    issue(MODE_RELEASE,  {32'd0, 32'hffff_ffff});
    issue(MODE_RELEASE,  '1);
    issue(MODE_RELEASE,  {32'hffff_ffff, 32'd1});
    issue(MODE_ALLOC,    '1);
    issue(MODE_QUERY,    {32'hffff_ffff, 32'd1});
    issue(MODE_QUERY,    '0);

    // Random part. The first segment leans hard on allocation so the pool
    // reaches its full size and the pool-full answer comes early.
    random_items = 0;
    first_seg    = 1'b1;
    while (random_items < 1850) begin
      seg_kind  = first_seg ? SEG_FILL : segment_e'($urandom_range(0, 2));
      seg_len   = first_seg ? 320 : $urandom_range(20, 250);
      first_seg = 1'b0;
      repeat (seg_len) begin
        mode = pick_mode(seg_kind);
        issue(mode, pick_handle());
        if (mode != MODE_RESERVED) random_items++;
      end
    end
    in_valid <= 1'b0;

    // Drain: every expected result must arrive, then allow for the longest scan.
    while (pending_count != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== generational_handle_allocator.f =====
hw/rtl/gha_pkg.sv
hw/rtl/gha_ram.sv
hw/rtl/generational_handle_allocator.sv
hw/rtl/gha_checker.sv
dv/gha_checker.sv
dv/tb_generational_handle_allocator.sv
